// File: rtl/core/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types, constants and the crc-8 byte update for the sensor frame
// decoder.
// ----------------------------------------------------------------------------
package hdf_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 3;
  localparam logic [1:0]  LAST_POS    = 2'(FRAME_BYTES - 1);

  // crc-8, polynomial 0x31 with the implicit top bit dropped
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'h00;

  // two low bits of the raw word are sensor status bits
  localparam logic [15:0] RAW_MASK    = 16'hfffc;

  // temperature conversion
  localparam logic [14:0] KELVIN_SLOPE  = 15'd17572;
  localparam logic [15:0] KELVIN_OFFSET = 16'd22630;
  localparam logic [16:0] CELSIUS_SHIFT = 17'd27315;
  localparam logic [16:0] FAHR_OFFSET   = 17'd3200;

  // reciprocal of 5 scaled by 2^18, exact for dividends below 2^18
  localparam logic [15:0] RECIP_5     = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 18;

  // humidity conversion
  localparam logic [10:0] HUM_SLOPE   = 11'd1250;
  localparam logic [10:0] HUM_OFFSET  = 11'd60;

  // one assembled frame waiting for conversion
  typedef struct packed {
    logic        ok;
    logic        kind;
    logic [15:0] raw;
  } hdf_frame_t;

  // crc-8 over one byte, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/hdf_front.sv
// ----------------------------------------------------------------------------
// hdf_front
// Takes frame bytes, runs the crc and assembles the raw word; on the last
// byte of a frame it hands one frame record to the queue.
// ----------------------------------------------------------------------------
module hdf_front
  import hdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] data_byte,
  input  logic       quantity,
  output logic       full,
  input  logic       q_full,
  output logic       q_push,
  output hdf_frame_t q_data
);

  logic [7:0] crc_accum;
  logic [1:0] byte_position;
  logic [7:0] high_byte;
  logic [7:0] low_byte;
  logic [7:0] crc_next;
  logic       last_byte;
  logic       accept;

  // only the closing byte needs room in the queue
  assign last_byte = (byte_position >= LAST_POS);
  assign full      = last_byte && q_full;
  assign accept    = push && !full;
  assign crc_next  = crc8_update(crc_accum, data_byte);

  // frame record for the queue
  assign q_push      = accept && last_byte;
  assign q_data.ok   = (crc_next == 8'h00);
  assign q_data.kind = quantity;
  assign q_data.raw  = {high_byte, low_byte} & RAW_MASK;

  // byte position and crc state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum     <= CRC_INIT;
      byte_position <= '0;
    end else if (accept) begin
      if (last_byte) begin
        crc_accum     <= CRC_INIT;
        byte_position <= '0;
      end else begin
        crc_accum     <= crc_next;
        byte_position <= byte_position + 2'd1;
      end
    end
  end

  // data bytes of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      high_byte <= '0;
      low_byte  <= '0;
    end else if (accept && !last_byte) begin
      if (byte_position == 2'd0) begin
        high_byte <= data_byte;
      end else begin
        low_byte <= data_byte;
      end
    end
  end

endmodule

// File: rtl/core/hdf_queue.sv
// ----------------------------------------------------------------------------
// hdf_queue
// Short first-in first-out queue of frame records between the byte front
// and the conversion pipeline.
// ----------------------------------------------------------------------------
module hdf_queue
  import hdf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  hdf_frame_t wr_data,
  output logic       q_full,
  output logic       rd_valid,
  input  logic       rd_en,
  output hdf_frame_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hdf_frame_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full   = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/core/hdf_back.sv
// ----------------------------------------------------------------------------
// hdf_back
// Three-stage conversion pipeline: constant multiplies, offsets and the
// fahrenheit scaling; the last stage is the result register.
// ----------------------------------------------------------------------------
module hdf_back
  import hdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_valid,
  input  hdf_frame_t         rd_data,
  output logic               rd_en,
  output logic               empty,
  input  logic               pop,
  output logic               crc_ok,
  output logic               frame_kind,
  output logic [15:0]        raw_value,
  output logic [15:0]        centikelvin,
  output logic signed [14:0] centicelsius,
  output logic signed [15:0] centifahrenheit,
  output logic [10:0]        humidity_ppth
);

  // stage 1: products
  logic        s1_valid;
  logic        s1_ok;
  logic        s1_kind;
  logic [15:0] s1_raw;
  logic [30:0] s1_prod_k;
  logic [26:0] s1_prod_h;

  // stage 2: offsets and scaled magnitude
  logic               s2_valid;
  logic               s2_ok;
  logic               s2_kind;
  logic [15:0]        s2_raw;
  logic [15:0]        s2_ck;
  logic signed [14:0] s2_cc;
  logic [10:0]        s2_hum;
  logic [16:0]        s2_mag9;
  logic               s2_neg;

  // stage 3 is the result register
  logic s3_valid;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  // stage 2 combinational terms
  logic [15:0]        ck_calc;
  logic signed [16:0] cc_wide;
  logic [16:0]        cc_abs;
  logic [10:0]        h_calc;
  logic [10:0]        hum_calc;

  // stage 3 combinational terms
  logic [32:0] q_prod;
  logic [14:0] q_calc;
  logic [16:0] cf_calc;
  logic        temp_en;
  logic        hum_en;

  // pipeline handshake
  assign s3_ready = !s3_valid || pop;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign rd_en    = rd_valid && s1_ready;
  assign empty    = !s3_valid;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= rd_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // stage 1: constant multiplies
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_ok     <= rd_data.ok;
      s1_kind   <= rd_data.kind;
      s1_raw    <= rd_data.raw;
      s1_prod_k <= 31'(rd_data.raw) * 31'(KELVIN_SLOPE);
      s1_prod_h <= 27'(rd_data.raw) * 27'(HUM_SLOPE);
    end
  end

  // kelvin, celsius and humidity offsets
  always_comb begin
    ck_calc  = KELVIN_OFFSET + 16'(s1_prod_k[30:16]);
    cc_wide  = $signed({1'b0, ck_calc}) - $signed(CELSIUS_SHIFT);
    cc_abs   = cc_wide[16] ? 17'(-cc_wide) : 17'(cc_wide);
    h_calc   = s1_prod_h[26:16];
    hum_calc = (h_calc > HUM_OFFSET) ? (h_calc - HUM_OFFSET) : 11'd0;
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_ok   <= s1_ok;
      s2_kind <= s1_kind;
      s2_raw  <= s1_raw;
      s2_ck   <= ck_calc;
      s2_cc   <= cc_wide[14:0];
      s2_hum  <= hum_calc;
      s2_mag9 <= {cc_abs[13:0], 3'b000} + 17'(cc_abs[13:0]);
      s2_neg  <= cc_wide[16];
    end
  end

  // divide the magnitude by 5, truncating, then restore the sign
  always_comb begin
    q_prod  = 33'(s2_mag9) * 33'(RECIP_5);
    q_calc  = q_prod[RECIP_SHIFT +: 15];
    cf_calc = s2_neg ? (FAHR_OFFSET - 17'(q_calc)) : (FAHR_OFFSET + 17'(q_calc));
    temp_en = s2_ok && s2_kind;
    hum_en  = s2_ok && !s2_kind;
  end

  // result register, fields of the other kind and failed frames read 0
  always_ff @(posedge clk) begin
    if (s3_ready) begin
      crc_ok          <= s2_ok;
      frame_kind      <= s2_kind;
      raw_value       <= s2_ok ? s2_raw : 16'd0;
      centikelvin     <= temp_en ? s2_ck : 16'd0;
      centicelsius    <= temp_en ? s2_cc : 15'sd0;
      centifahrenheit <= temp_en ? $signed(cf_calc[15:0]) : 16'sd0;
      humidity_ppth   <= hum_en ? s2_hum : 11'd0;
    end
  end

endmodule

// File: rtl/core/humidity_temp_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Sensor measurement frame decoder: crc-8 check and unit conversion of a
// three-byte humidity or temperature frame.
// ----------------------------------------------------------------------------
// Push the frame bytes in order msb, lsb, crc; the quantity bit sampled with
// the crc byte selects temperature (1) or humidity (0). One byte is taken
// every clock cycle while full is low, and each third byte produces one
// result beat, readable once it has passed the frame queue, the stage 1 and
// stage 2 registers and the result register, held until popped. full is
// raised only on the crc byte of a frame, and only while the frame queue
// (QUEUE_DEPTH entries) is full because results are not being popped; the
// rate is set by the byte front, which runs the crc over one byte per cycle.
// A failed crc gives crc_ok low and all value fields zero.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top
  import hdf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               quantity,
  output logic               empty,
  input  logic               pop,
  output logic               crc_ok,
  output logic               frame_kind,
  output logic [15:0]        raw_value,
  output logic [15:0]        centikelvin,
  output logic signed [14:0] centicelsius,
  output logic signed [15:0] centifahrenheit,
  output logic [10:0]        humidity_ppth
);

  logic       q_full;
  logic       q_push;
  hdf_frame_t q_wr_data;
  logic       q_rd_valid;
  logic       q_rd_en;
  hdf_frame_t q_rd_data;

  // byte front: crc and frame assembly
  hdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .quantity  (quantity),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // frame queue
  hdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .q_full   (q_full),
    .rd_valid (q_rd_valid),
    .rd_en    (q_rd_en),
    .rd_data  (q_rd_data)
  );

  // conversion pipeline and result register
  hdf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .rd_valid        (q_rd_valid),
    .rd_data         (q_rd_data),
    .rd_en           (q_rd_en),
    .empty           (empty),
    .pop             (pop),
    .crc_ok          (crc_ok),
    .frame_kind      (frame_kind),
    .raw_value       (raw_value),
    .centikelvin     (centikelvin),
    .centicelsius    (centicelsius),
    .centifahrenheit (centifahrenheit),
    .humidity_ppth   (humidity_ppth)
  );

endmodule
